// ===== src/ukst_pkg.sv =====
// Shared types and codes for the unique-key stack.
`timescale 1ns / 1ps

package ukst_pkg;

   // Operation codes carried by req_type.
   typedef enum logic [1:0] {
      OP_PUSH = 2'd0,
      OP_POP  = 2'd1,
      OP_PEEK = 2'd2
   } op_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_DUP   = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   localparam int KEY_W = 32;
   localparam int PAYLOAD_W = 32;
   localparam int OCC_W = 8;
   localparam int SERVED_W = 32;

   // One stored record.
   typedef struct packed {
      logic [KEY_W-1:0]     key;
      logic [PAYLOAD_W-1:0] payload;
   } record_type;

   // Commands broadcast to every cell of the chain.
   typedef struct packed {
      logic             shift_push;
      logic             shift_pop;
      logic             compare;
      logic [KEY_W-1:0] cmp_key;
   } cell_cmd_type;

endpackage

// ===== src/ukst_cell.sv =====
// One stack cell: holds a record, shifts with its neighbours and checks its key.
`timescale 1ns / 1ps

module ukst_cell (
   input  logic                 clock,
   input  ukst_pkg::cell_cmd_type cmd,
   input  logic                 live,
   input  ukst_pkg::record_type above,
   input  ukst_pkg::record_type below,
   output ukst_pkg::record_type data,
   output logic                 match
);
   import ukst_pkg::*;

   record_type data_ff;
   logic       match_ff;

   // A push moves every record one place down the chain, a pop one place up.
   always_ff @(posedge clock) begin
      if (cmd.shift_push) begin
         data_ff <= above;
      end else if (cmd.shift_pop) begin
         data_ff <= below;
      end
   end

   // Only cells that currently hold a record may report a match.
   always_ff @(posedge clock) begin
      if (cmd.compare) begin
         match_ff <= live && (data_ff.key == cmd.cmp_key);
      end
   end

   assign data  = data_ff;
   assign match = match_ff;

endmodule

// ===== src/unique_key_stack_top.sv =====
// Top level of the unique-key stack: cell chain, request handling and result register.
`timescale 1ns / 1ps

// A bounded LIFO of key/payload records built as a chain of STACK_DEPTH cells, the top
// record always in the first cell. For each transfer, in the accept cycle
// every cell compares its key against the request key in parallel and registers a match
// flag; in the next cycle the flags are ORed, the chain shifts by one place for a push
// or a pop, and the result is loaded into the output register. No request is accepted
// while one executes or while a result waits untaken. A push onto a full stack reports
// full without a key check; pop and peek on an empty stack report empty with zero data.
// No clearing pass is needed after reset: only cells below the occupancy count are live.

module unique_key_stack_top #(
   parameter int STACK_DEPTH = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_type,
   input  logic signed [ukst_pkg::KEY_W-1:0]   req_call_key,
   input  logic [ukst_pkg::PAYLOAD_W-1:0]      req_call_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic signed [ukst_pkg::KEY_W-1:0]   rsp_out_key,
   output logic [ukst_pkg::PAYLOAD_W-1:0]      rsp_out_payload,
   output logic [ukst_pkg::OCC_W-1:0]          rsp_occupancy,
   output logic [ukst_pkg::SERVED_W-1:0]       rsp_served_count
);
   import ukst_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);

   logic                  busy_ff;
   logic [1:0]            op_ff;
   record_type            req_rec_ff;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;
   logic [SERVED_W-1:0]   served_ff;
   logic [SERVED_W-1:0]   served_in;

   logic                  rsp_valid_ff;
   logic [1:0]            status_ff;
   logic [1:0]            status_in;
   record_type            out_rec_ff;
   record_type            out_rec_in;

   logic                  accept;
   logic                  full;
   logic                  empty;
   logic                  dup;
   logic                  push_do;
   logic                  pop_do;
   cell_cmd_type          cmd;

   logic       [STACK_DEPTH-1:0] live;
   logic       [STACK_DEPTH-1:0] match;
   record_type [STACK_DEPTH-1:0] cell_data;

   assign req_ready = !busy_ff && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   // Request register and one-cycle busy flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff              <= req_type;
         req_rec_ff.key     <= req_call_key;
         req_rec_ff.payload <= req_call_payload;
      end
   end

   assign full  = count_ff >= CW'(STACK_DEPTH);
   assign empty = count_ff == '0;
   assign dup   = |match;

   always_comb begin
      push_do    = 1'b0;
      pop_do     = 1'b0;
      status_in  = ST_OK;
      out_rec_in = '0;
      count_in   = count_ff;
      served_in  = served_ff;
      if (busy_ff) begin
         case (op_ff)
            OP_PUSH: begin
               if (full) begin
                  status_in = ST_FULL;
               end else if (dup) begin
                  status_in = ST_DUP;
               end else begin
                  push_do  = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            OP_POP, OP_PEEK: begin
               if (empty) begin
                  status_in = ST_EMPTY;
               end else begin
                  out_rec_in = cell_data[0];
                  if (op_ff == OP_POP) begin
                     pop_do   = 1'b1;
                     count_in = count_ff - 1'b1;
                     if (served_ff != '1) begin
                        served_in = served_ff + 1'b1;
                     end
                  end
               end
            end
            default: begin
               status_in = ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         served_ff <= '0;
      end else begin
         count_ff  <= count_in;
         served_ff <= served_in;
      end
   end

   // Output register; it is always free again by the time a request executes.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (busy_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (busy_ff) begin
         status_ff  <= status_in;
         out_rec_ff <= out_rec_in;
      end
   end

   assign cmd.shift_push = push_do;
   assign cmd.shift_pop  = pop_do;
   assign cmd.compare    = accept;
   assign cmd.cmp_key    = req_call_key;

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      record_type above;
      record_type below;

      if (i == 0) begin : g_first
         assign above = req_rec_ff;
      end else begin : g_inner
         assign above = cell_data[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_last
         assign below = '0;
      end else begin : g_rest
         assign below = cell_data[i+1];
      end

      assign live[i] = count_ff > CW'(i);

      ukst_cell u_cell (
         .clock (clock),
         .cmd   (cmd),
         .live  (live[i]),
         .above (above),
         .below (below),
         .data  (cell_data[i]),
         .match (match[i])
      );
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_key      = $signed(out_rec_ff.key);
   assign rsp_out_payload  = out_rec_ff.payload;
   assign rsp_occupancy    = OCC_W'(count_ff);
   assign rsp_served_count = served_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STACK_DEPTH))
      else $error("occupancy above stack depth");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req_ready)
      else $error("request accepted while executing");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push_do |=> (count_ff == $past(count_ff) + 1'b1) && (status_ff == ST_OK))
      else $error("served push did not grow the stack");

   a_empty_holds: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && empty && (op_ff == OP_POP || op_ff == OP_PEEK))
         |=> (count_ff == '0) && (status_ff == ST_EMPTY))
      else $error("empty pop or peek changed state");

   a_served_monotonic: assert property (@(posedge clock) disable iff (reset)
      !reset |=> served_ff >= $past(served_ff))
      else $error("served count went down");

endmodule

// ===== bench/tb.sv =====
// Self-checking testbench for the unique-key stack: directed table, random bursts, predictor.
`timescale 1ns / 1ps

module tb;
   import ukst_pkg::*;

   localparam int STACK_DEPTH = 128;
   // The selector value that the block leaves unused; it must still answer with OK.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      status_type            status;
      logic [KEY_W-1:0]      key;
      logic [PAYLOAD_W-1:0]  payload;
      logic [OCC_W-1:0]      occupancy;
      logic [SERVED_W-1:0]   served;
   } stack_result_type;

   typedef struct packed {
      logic [1:0]            op;
      logic [KEY_W-1:0]      key;
      logic [PAYLOAD_W-1:0]  payload;
      logic                  typed;
      stack_result_type      want;
   } stim_row_type;

   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} burst_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [1:0]            req_type = 2'd0;
   logic [KEY_W-1:0]      req_call_key = '0;
   logic [PAYLOAD_W-1:0]  req_call_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [1:0]            rsp_status;
   logic [KEY_W-1:0]      rsp_out_key;
   logic [PAYLOAD_W-1:0]  rsp_out_payload;
   logic [OCC_W-1:0]      rsp_occupancy;
   logic [SERVED_W-1:0]   rsp_served_count;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatch_count = 0;

   // Mirror of the stack contents, bottom record at index 0.
   logic [KEY_W-1:0]      mirror_keys [STACK_DEPTH];
   logic [PAYLOAD_W-1:0]  mirror_payloads [STACK_DEPTH];
   int unsigned           mirror_count = 0;
   logic [SERVED_W-1:0]   mirror_served = '0;

   stack_result_type pending_results [$];

   stim_row_type directed_rows [23] = '{
      '{OP_POP,    32'h0000_0000, 32'h0000_0000, 1'b1,
        '{ST_EMPTY, 32'h0, 32'h0, 8'd0, 32'd0}},
      '{OP_PEEK,   32'h0000_0000, 32'h0000_0000, 1'b1,
        '{ST_EMPTY, 32'h0, 32'h0, 8'd0, 32'd0}},
      '{OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
        '{ST_OK, 32'h0, 32'h0, 8'd0, 32'd0}},
      '{OP_PUSH,   32'h8000_0000, 32'h0000_0000, 1'b1,
        '{ST_OK, 32'h0, 32'h0, 8'd1, 32'd0}},
      '{OP_PUSH,   32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1,
        '{ST_OK, 32'h0, 32'h0, 8'd2, 32'd0}},
      '{OP_PUSH,   32'h8000_0000, 32'h1234_5678, 1'b1,
        '{ST_DUP, 32'h0, 32'h0, 8'd2, 32'd0}},
      '{OP_PUSH,   32'h0000_0000, 32'h5A5A_5A5A, 1'b0, '0},
      '{OP_PUSH,   32'hFFFF_FFFF, 32'hA5A5_A5A5, 1'b0, '0},
      '{OP_PUSH,   32'h0000_0000, 32'h0000_0000, 1'b1,
        '{ST_DUP, 32'h0, 32'h0, 8'd4, 32'd0}},
      '{OP_PUSH,   32'h7FFF_FFFF, 32'h0000_0000, 1'b1,
        '{ST_DUP, 32'h0, 32'h0, 8'd4, 32'd0}},
      '{OP_PEEK,   32'h0000_0000, 32'h0000_0000, 1'b1,
        '{ST_OK, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 8'd4, 32'd0}},
      '{OP_UNUSED, 32'h0000_0001, 32'h0000_0001, 1'b1,
        '{ST_OK, 32'h0, 32'h0, 8'd4, 32'd0}},
      '{OP_POP,    32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{OP_POP,    32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{OP_PUSH,   32'hFFFF_FFFF, 32'h0000_0001, 1'b1,
        '{ST_OK, 32'h0, 32'h0, 8'd3, 32'd2}},
      '{OP_PEEK,   32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{OP_POP,    32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{OP_POP,    32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{OP_POP,    32'h0000_0000, 32'h0000_0000, 1'b0, '0},
      '{OP_POP,    32'h0000_0000, 32'h0000_0000, 1'b1,
        '{ST_EMPTY, 32'h0, 32'h0, 8'd0, 32'd5}},
      '{OP_PEEK,   32'h0000_0000, 32'h0000_0000, 1'b1,
        '{ST_EMPTY, 32'h0, 32'h0, 8'd0, 32'd5}},
      '{OP_PUSH,   32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '0},
      '{OP_POP,    32'h0000_0000, 32'h0000_0000, 1'b0, '0}
   };

   unique_key_stack_top #(
      .STACK_DEPTH(STACK_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type(req_type),
      .req_call_key(req_call_key),
      .req_call_payload(req_call_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_out_key(rsp_out_key),
      .rsp_out_payload(rsp_out_payload),
      .rsp_occupancy(rsp_occupancy),
      .rsp_served_count(rsp_served_count)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         $display("tb: mismatch on %s at %0t: got %h, expected %h", what, $time, got, want);
         mismatch_count++;
      end
   endtask

   // Applies one operation to the mirror and returns the result the block should give.
   function automatic stack_result_type stack_apply(input logic [1:0] op,
                                                    input logic [KEY_W-1:0] key,
                                                    input logic [PAYLOAD_W-1:0] payload);
      stack_result_type res;
      bit               hit;
      res = '0;
      res.status = ST_OK;
      hit = 1'b0;
      case (op)
         OP_PUSH: begin
            if (mirror_count >= STACK_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               for (int i = 0; i < mirror_count; i++) begin
                  if (mirror_keys[i] == key) hit = 1'b1;
               end
               if (hit) begin
                  res.status = ST_DUP;
               end else begin
                  mirror_keys[mirror_count] = key;
                  mirror_payloads[mirror_count] = payload;
                  mirror_count++;
               end
            end
         end
         OP_POP, OP_PEEK: begin
            if (mirror_count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.key = mirror_keys[mirror_count - 1];
               res.payload = mirror_payloads[mirror_count - 1];
               if (op == OP_POP) begin
                  mirror_count--;
                  if (mirror_served != '1) mirror_served++;
               end
            end
         end
         default: ;
      endcase
      res.occupancy = OCC_W'(mirror_count);
      res.served = mirror_served;
      return res;
   endfunction

   function automatic logic [1:0] pick_op(input burst_mode_type mode);
      int r;
      int push_pct;
      int pop_pct;
      int peek_pct;
      r = $urandom_range(0, 99);
      case (mode)
         MODE_FILL:  begin push_pct = 84; pop_pct = 6;  peek_pct = 6;  end
         MODE_DRAIN: begin push_pct = 16; pop_pct = 66; peek_pct = 14; end
         default:    begin push_pct = 46; pop_pct = 34; peek_pct = 16; end
      endcase
      if (r < push_pct) return OP_PUSH;
      if (r < push_pct + pop_pct) return OP_POP;
      if (r < push_pct + pop_pct + peek_pct) return OP_PEEK;
      return OP_UNUSED;
   endfunction

   // Keys are drawn from the stored records, a handful of extremes, or the whole range.
   function automatic logic [KEY_W-1:0] pick_key(input burst_mode_type mode);
      int r;
      int dup_pct;
      r = $urandom_range(0, 99);
      case (mode)
         MODE_FILL:  dup_pct = 15;
         MODE_DRAIN: dup_pct = 40;
         default:    dup_pct = 30;
      endcase
      if (mirror_count > 0 && r < dup_pct) begin
         return mirror_keys[$urandom_range(0, mirror_count - 1)];
      end
      if (r < dup_pct + 12) begin
         case ($urandom_range(0, 4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
         endcase
      end
      return $urandom;
   endfunction

   // Called just after the clock has changed; it assigns req_valid only after waiting on the falling clock.
   task automatic send_item(input logic [1:0] op, input logic [KEY_W-1:0] key,
                            input logic [PAYLOAD_W-1:0] payload, input logic typed,
                            input stack_result_type typed_want);
      stack_result_type predicted;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= op;
      req_call_key <= key;
      req_call_payload <= payload;
      do @(posedge clock); while (!req_ready);
      predicted = stack_apply(op, key, payload);
      pending_results.push_back(typed ? typed_want : predicted);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   always @(posedge clock) begin
      stack_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            check_field("transfer with nothing outstanding", 32'd1, 32'd0);
         end else begin
            want = pending_results.pop_front();
            check_field("status", rsp_status, want.status);
            check_field("out_key", rsp_out_key, want.key);
            check_field("out_payload", rsp_out_payload, want.payload);
            check_field("occupancy", rsp_occupancy, want.occupancy);
            check_field("served_count", rsp_served_count, want.served);
         end
      end
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      int             send_pcts [3];
      int             recv_pcts [3];
      int             burst_left;
      burst_mode_type mode;
      logic [1:0]     op;
      send_pcts = '{29, 75, 0};
      recv_pcts = '{75, 29, 0};
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = send_pcts[0];
      recv_idle_pct = recv_pcts[0];
      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].op, directed_rows[i].key, directed_rows[i].payload,
                   directed_rows[i].typed, directed_rows[i].want);
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = send_pcts[phase];
         recv_idle_pct = recv_pcts[phase];
         // Each phase opens with a long filling burst so that the full stack is reached.
         mode = MODE_FILL;
         burst_left = $urandom_range(260, 320);
         for (int n = 0; n < 576; n++) begin
            if (burst_left == 0) begin
               mode = burst_mode_type'($urandom_range(0, 2));
               burst_left = $urandom_range(20, 200);
            end
            burst_left--;
            op = pick_op(mode);
            send_item(op, pick_key(mode), $urandom, 1'b0, '0);
            if ($urandom_range(0, 299) == 0) wait_drained();
         end
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (pending_results.size() != 0) begin
         check_field("results outstanding at end", pending_results.size(), 32'd0);
      end
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
